@@ rtl/knps_pkg.sv @@
`timescale 1ns / 1ps
// knps_pkg: shared widths, constants, register indexes, state codes and
// controller/datapath command and status structs for the k-nearest selector
// no dependencies

package knps_pkg;

    localparam int COORD_W = 12;
    localparam int ID_W    = 16;
    localparam int LIMIT_W = 25;
    localparam int SQ_W    = 24;
    localparam int CAND_W  = 25;
    localparam int DIST_W  = 49;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam int K_DEFAULT = 7;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 25'd16777216;
    localparam logic [DIST_W-1:0]  DIST_RESET  = 49'h1_0000_0000_0000;
    localparam logic [DIST_W-1:0]  DIST_MAX    = {DIST_W{1'b1}};

    // register indexes, byte address is 4 * index
    localparam logic [1:0] REG_QUERY_X = 2'd0;
    localparam logic [1:0] REG_QUERY_Y = 2'd1;
    localparam logic [1:0] REG_LIMIT   = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_SQUARE  = 5'b00010,
        S_COMPARE = 5'b00100,
        S_SCAN    = 5'b01000,
        S_EMIT    = 5'b10000
    } state_t;

    typedef struct packed {
        logic capture;
        logic square;
        logic compare;
        logic scan;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic replace;
        logic last_item;
        logic scan_done;
        logic emit_done;
        logic out_free;
    } dpath_status_t;

endpackage

@@ rtl/k_nearest_point_selector_unit.sv @@
`timescale 1ns / 1ps
// k_nearest_point_selector_unit: top level of the k-nearest point selector
// instantiates knps_cfg, knps_ctrl and knps_dpath; uses knps_pkg
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------------
//  input    | in_valid / in_stall | first, last, cand_x, cand_y, cand_id
//  output   | out_valid/out_stall | slot_valid, neighbour_id, neighbour_dist_sq,
//           |                     | slot_last
//  config   | psel/penable/pready | paddr, pwrite, pwdata, prdata
//
// a candidate goes through capture, square and compare, and through the worst-slot
// rescan as well when it replaces a slot; the rescan reads one slot a cycle
// an item marked last then adds K result transactions, one per cycle while the
// output side takes them, the output register lets the next candidate be accepted
// while the final slot still waits
// rst_n clears the slots to 2^48 with id zero, worst slot to zero, limit to 2^24
// out_stall holds the output register and the emit sequence, in_stall is high while an item is in work

module k_nearest_point_selector_unit
#(
    parameter int K = knps_pkg::K_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,

    // candidate transactions
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              first,
    input  logic                              last,
    input  logic [knps_pkg::COORD_W-1:0]      cand_x,
    input  logic [knps_pkg::COORD_W-1:0]      cand_y,
    input  logic [knps_pkg::ID_W-1:0]         cand_id,

    // neighbour slot transactions
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              slot_valid,
    output logic [knps_pkg::ID_W-1:0]         neighbour_id,
    output logic [knps_pkg::DIST_W-1:0]       neighbour_dist_sq,
    output logic                              slot_last,

    // register access
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [knps_pkg::ADDR_W-1:0]       paddr,
    input  logic [knps_pkg::DATA_W-1:0]       pwdata,
    output logic [knps_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);

    // query point and limit squared; user keeps them stable while a candidate is in work, not enforced by the block
    logic [knps_pkg::COORD_W-1:0] query_x;
    logic [knps_pkg::COORD_W-1:0] query_y;
    logic [knps_pkg::DIST_W-1:0]  limit_sq;

    // controller to datapath and back
    knps_pkg::ctrl_cmd_t     cmd;
    knps_pkg::dpath_status_t status;

    knps_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .query_x  (query_x),
        .query_y  (query_y),
        .limit_sq (limit_sq)
    );

    // sequencer: capture, square, compare, rescan, emit
    knps_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // slot store, distance arithmetic and output register
    knps_dpath
    #(
        .K (K)
    )
    u_dpath
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .first             (first),
        .last              (last),
        .cand_x            (cand_x),
        .cand_y            (cand_y),
        .cand_id           (cand_id),
        .query_x           (query_x),
        .query_y           (query_y),
        .limit_sq          (limit_sq),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .slot_valid        (slot_valid),
        .neighbour_id      (neighbour_id),
        .neighbour_dist_sq (neighbour_dist_sq),
        .slot_last         (slot_last)
    );

endmodule

@@ rtl/knps_cfg.sv @@
`timescale 1ns / 1ps
// knps_cfg: configuration registers behind the apb-style port and the
// registered square of the limit distance, saturated only when product bit 49 is set; uses knps_pkg

module knps_cfg
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [knps_pkg::ADDR_W-1:0]          paddr,
    input  logic [knps_pkg::DATA_W-1:0]          pwdata,
    output logic [knps_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready,
    output logic [knps_pkg::COORD_W-1:0]         query_x,
    output logic [knps_pkg::COORD_W-1:0]         query_y,
    output logic [knps_pkg::DIST_W-1:0]          limit_sq
);

    logic [knps_pkg::COORD_W-1:0] query_x_reg, query_x_next;
    logic [knps_pkg::COORD_W-1:0] query_y_reg, query_y_next;
    logic [knps_pkg::LIMIT_W-1:0] limit_reg, limit_next;
    logic [knps_pkg::DIST_W-1:0]  limit_sq_reg, limit_sq_next;
    logic [2*knps_pkg::LIMIT_W-1:0] limit_prod;
    logic [1:0] reg_index;
    logic       wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite;

    always_comb
    begin
        query_x_next = query_x_reg;
        query_y_next = query_y_reg;
        limit_next   = limit_reg;
        if (wr_en)
        begin
            case (reg_index)
                knps_pkg::REG_QUERY_X: query_x_next = pwdata[knps_pkg::COORD_W-1:0];
                knps_pkg::REG_QUERY_Y: query_y_next = pwdata[knps_pkg::COORD_W-1:0];
                knps_pkg::REG_LIMIT:   limit_next   = pwdata[knps_pkg::LIMIT_W-1:0];
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            knps_pkg::REG_QUERY_X:
                prdata = {{(knps_pkg::DATA_W-knps_pkg::COORD_W){1'b0}}, query_x_reg};
            knps_pkg::REG_QUERY_Y:
                prdata = {{(knps_pkg::DATA_W-knps_pkg::COORD_W){1'b0}}, query_y_reg};
            knps_pkg::REG_LIMIT:
                prdata = {{(knps_pkg::DATA_W-knps_pkg::LIMIT_W){1'b0}}, limit_reg};
            default:
                prdata = '0;
        endcase
    end

    // square follows the limit in the next cycle, all ones only when product bit 49 is set, else truncated
    assign limit_prod = {{knps_pkg::LIMIT_W{1'b0}}, limit_reg} *
                        {{knps_pkg::LIMIT_W{1'b0}}, limit_reg};
    assign limit_sq_next = limit_prod[2*knps_pkg::LIMIT_W-1] ? knps_pkg::DIST_MAX
                         : limit_prod[knps_pkg::DIST_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_x_reg  <= '0;
            query_y_reg  <= '0;
            limit_reg    <= knps_pkg::LIMIT_RESET;
            limit_sq_reg <= knps_pkg::DIST_RESET;
        end
        else
        begin
            query_x_reg  <= query_x_next;
            query_y_reg  <= query_y_next;
            limit_reg    <= limit_next;
            limit_sq_reg <= limit_sq_next;
        end
    end

    assign query_x  = query_x_reg;
    assign query_y  = query_y_reg;
    assign limit_sq = limit_sq_reg;

endmodule

@@ rtl/knps_ctrl.sv @@
`timescale 1ns / 1ps
// knps_ctrl: one-hot sequencer for capture, square, compare, rescan and emit
// uses knps_pkg state and command/status types

module knps_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  knps_pkg::dpath_status_t status,
    output knps_pkg::ctrl_cmd_t     cmd
);

    knps_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            knps_pkg::S_IDLE:
                if (in_valid)
                    state_next = knps_pkg::S_SQUARE;
            knps_pkg::S_SQUARE:
                state_next = knps_pkg::S_COMPARE;
            knps_pkg::S_COMPARE:
            begin
                priority if (status.replace)
                    state_next = knps_pkg::S_SCAN;
                else if (status.last_item)
                    state_next = knps_pkg::S_EMIT;
                else
                    state_next = knps_pkg::S_IDLE;
            end
            knps_pkg::S_SCAN:
                if (status.scan_done)
                    state_next = status.last_item ? knps_pkg::S_EMIT : knps_pkg::S_IDLE;
            knps_pkg::S_EMIT:
                if (status.out_free && status.emit_done)
                    state_next = knps_pkg::S_IDLE;
            default:
                state_next = knps_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= knps_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall    = (state_reg != knps_pkg::S_IDLE);
    assign cmd.capture = (state_reg == knps_pkg::S_IDLE) && in_valid;
    assign cmd.square  = (state_reg == knps_pkg::S_SQUARE);
    assign cmd.compare = (state_reg == knps_pkg::S_COMPARE);
    assign cmd.scan    = (state_reg == knps_pkg::S_SCAN);
    assign cmd.emit    = (state_reg == knps_pkg::S_EMIT);

endmodule

@@ rtl/knps_dpath.sv @@
`timescale 1ns / 1ps
// knps_dpath: candidate registers, squared distance, slot registers, worst-slot
// rescan and the result output register; uses knps_pkg

module knps_dpath
#(
    parameter int K = knps_pkg::K_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  knps_pkg::ctrl_cmd_t               cmd,
    output knps_pkg::dpath_status_t           status,
    input  logic                              first,
    input  logic                              last,
    input  logic [knps_pkg::COORD_W-1:0]      cand_x,
    input  logic [knps_pkg::COORD_W-1:0]      cand_y,
    input  logic [knps_pkg::ID_W-1:0]         cand_id,
    input  logic [knps_pkg::COORD_W-1:0]      query_x,
    input  logic [knps_pkg::COORD_W-1:0]      query_y,
    input  logic [knps_pkg::DIST_W-1:0]       limit_sq,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              slot_valid,
    output logic [knps_pkg::ID_W-1:0]         neighbour_id,
    output logic [knps_pkg::DIST_W-1:0]       neighbour_dist_sq,
    output logic                              slot_last
);

    localparam int W = (K > 1) ? $clog2(K) : 1;
    localparam logic [W-1:0] IDX_LAST = W'(K - 1);

    logic                          first_reg, first_next;
    logic                          last_reg, last_next;
    logic [knps_pkg::COORD_W-1:0]  cx_reg, cx_next;
    logic [knps_pkg::COORD_W-1:0]  cy_reg, cy_next;
    logic [knps_pkg::ID_W-1:0]     cid_reg, cid_next;
    logic [knps_pkg::SQ_W-1:0]     sqx_reg, sqx_next;
    logic [knps_pkg::SQ_W-1:0]     sqy_reg, sqy_next;

    logic [knps_pkg::DIST_W-1:0]   slot_dist_reg [K];
    logic [knps_pkg::DIST_W-1:0]   slot_dist_next [K];
    logic [knps_pkg::ID_W-1:0]     slot_id_reg [K];
    logic [knps_pkg::ID_W-1:0]     slot_id_next [K];

    logic [W-1:0]                  worst_idx_reg, worst_idx_next;
    logic [knps_pkg::DIST_W-1:0]   worst_dist_reg, worst_dist_next;
    logic [W-1:0]                  scan_w_reg, scan_w_next;
    logic [knps_pkg::DIST_W-1:0]   scan_wd_reg, scan_wd_next;
    logic [W-1:0]                  idx_reg, idx_next;

    logic                          out_valid_reg, out_valid_next;
    logic                          out_slot_valid_reg, out_slot_valid_next;
    logic [knps_pkg::ID_W-1:0]     out_id_reg, out_id_next;
    logic [knps_pkg::DIST_W-1:0]   out_dist_reg, out_dist_next;
    logic                          out_last_reg, out_last_next;

    logic [knps_pkg::COORD_W-1:0]  dx, dy;
    logic [knps_pkg::CAND_W-1:0]   cand_sum;
    logic [knps_pkg::DIST_W-1:0]   cand_dist;
    logic [knps_pkg::DIST_W-1:0]   rd_dist;
    logic [knps_pkg::ID_W-1:0]     rd_id;
    logic [W-1:0]                  step_w;
    logic [knps_pkg::DIST_W-1:0]   step_wd;
    logic                          idx_at_last;
    logic                          replace;
    logic                          out_free;

    assign dx = (cx_reg >= query_x) ? cx_reg - query_x : query_x - cx_reg;
    assign dy = (cy_reg >= query_y) ? cy_reg - query_y : query_y - cy_reg;
    assign sqx_next = dx * dx;
    assign sqy_next = dy * dy;

    assign cand_sum  = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign cand_dist = {{(knps_pkg::DIST_W-knps_pkg::CAND_W){1'b0}}, cand_sum};
    // same x as the query skips the candidate, ties with the worst are rejected
    assign replace   = (cx_reg != query_x) && (cand_dist < worst_dist_reg);

    assign rd_dist     = slot_dist_reg[idx_reg];
    assign rd_id       = slot_id_reg[idx_reg];
    assign idx_at_last = (idx_reg == IDX_LAST);

    // in-order strictly-greater rescan, one slot per cycle
    assign step_w  = (rd_dist > scan_wd_reg) ? idx_reg : scan_w_reg;
    assign step_wd = (rd_dist > scan_wd_reg) ? rd_dist : scan_wd_reg;

    assign out_free = !out_valid_reg || !out_stall;

    assign first_next = cmd.capture ? first   : first_reg;
    assign last_next  = cmd.capture ? last    : last_reg;
    assign cx_next    = cmd.capture ? cand_x  : cx_reg;
    assign cy_next    = cmd.capture ? cand_y  : cy_reg;
    assign cid_next   = cmd.capture ? cand_id : cid_reg;

    always_comb
    begin
        slot_dist_next      = slot_dist_reg;
        slot_id_next        = slot_id_reg;
        worst_idx_next      = worst_idx_reg;
        worst_dist_next     = worst_dist_reg;
        scan_w_next         = scan_w_reg;
        scan_wd_next        = scan_wd_reg;
        idx_next            = idx_reg;
        out_valid_next      = out_valid_reg;
        out_slot_valid_next = out_slot_valid_reg;
        out_id_next         = out_id_reg;
        out_dist_next       = out_dist_reg;
        out_last_next       = out_last_reg;

        if (cmd.square && first_reg)
        begin
            for (int i = 0; i < K; i++)
            begin
                slot_dist_next[i] = limit_sq;
                slot_id_next[i]   = '0;
            end
            worst_idx_next  = '0;
            worst_dist_next = limit_sq;
        end

        if (cmd.compare && replace)
        begin
            slot_dist_next[worst_idx_reg] = cand_dist;
            slot_id_next[worst_idx_reg]   = cid_reg;
            scan_w_next                   = worst_idx_reg;
            scan_wd_next                  = cand_dist;
        end

        if (cmd.scan)
        begin
            scan_w_next  = step_w;
            scan_wd_next = step_wd;
            idx_next     = idx_at_last ? '0 : idx_reg + 1'b1;
            if (idx_at_last)
            begin
                worst_idx_next  = step_w;
                worst_dist_next = step_wd;
            end
        end

        if (cmd.emit && out_free)
        begin
            out_valid_next      = 1'b1;
            out_slot_valid_next = (rd_dist < limit_sq);
            out_id_next         = rd_id;
            out_dist_next       = rd_dist;
            out_last_next       = idx_at_last;
            idx_next            = idx_at_last ? '0 : idx_reg + 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < K; i++)
            begin
                slot_dist_reg[i] <= knps_pkg::DIST_RESET;
                slot_id_reg[i]   <= '0;
            end
            worst_idx_reg  <= '0;
            worst_dist_reg <= knps_pkg::DIST_RESET;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            slot_dist_reg  <= slot_dist_next;
            slot_id_reg    <= slot_id_next;
            worst_idx_reg  <= worst_idx_next;
            worst_dist_reg <= worst_dist_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg          <= first_next;
        last_reg           <= last_next;
        cx_reg             <= cx_next;
        cy_reg             <= cy_next;
        cid_reg            <= cid_next;
        sqx_reg            <= sqx_next;
        sqy_reg            <= sqy_next;
        scan_w_reg         <= scan_w_next;
        scan_wd_reg        <= scan_wd_next;
        out_slot_valid_reg <= out_slot_valid_next;
        out_id_reg         <= out_id_next;
        out_dist_reg       <= out_dist_next;
        out_last_reg       <= out_last_next;
    end

    assign status.replace   = replace;
    assign status.last_item = last_reg;
    assign status.scan_done = idx_at_last;
    assign status.emit_done = idx_at_last;
    assign status.out_free  = out_free;

    assign out_valid         = out_valid_reg;
    assign slot_valid        = out_slot_valid_reg;
    assign neighbour_id      = out_id_reg;
    assign neighbour_dist_sq = out_dist_reg;
    assign slot_last         = out_last_reg;

    // cached worst distance must match the slot it points at between items
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> (worst_dist_reg == slot_dist_reg[worst_idx_reg]))
        else $error("worst distance cache out of step with slots");

    // slot index is back at zero whenever a new candidate arrives
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> (idx_reg == '0))
        else $error("slot index not rewound at capture");

    // rescan candidate worst tracks the slot it names
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan |-> (scan_wd_reg == slot_dist_reg[scan_w_reg]))
        else $error("rescan worst distance does not match its slot");

    // the final slot of a run closes the emit sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && out_free && idx_at_last) |=> (out_valid_reg && out_last_reg))
        else $error("final slot not flagged");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// testbench: self-checking bench for the k-nearest point selector
// drives candidate runs and register writes, checks every slot transaction
// against a built-in selection model or a typed-in slot dump; depends on knps_pkg and the selector rtl

module testbench;

    localparam int K       = knps_pkg::K_DEFAULT;
    localparam int COORD_W = knps_pkg::COORD_W;
    localparam int ID_W    = knps_pkg::ID_W;
    localparam int LIMIT_W = knps_pkg::LIMIT_W;
    localparam int DIST_W  = knps_pkg::DIST_W;
    localparam int ADDR_W  = knps_pkg::ADDR_W;
    localparam int DATA_W  = knps_pkg::DATA_W;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = knps_pkg::LIMIT_RESET;
    localparam logic [DIST_W-1:0]  DIST_RESET  = knps_pkg::DIST_RESET;
    localparam logic [DIST_W-1:0]  DIST_MAX    = knps_pkg::DIST_MAX;

    localparam int SETTLE = 2 * K + 6;   // cycles for an item in work to drain
    localparam int RANDOM_ITEMS = 300;

    // register index with no register behind it, writes must be ignored
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // one candidate transaction
    typedef struct packed {
        logic               first;
        logic               last;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [ID_W-1:0]    id;
    } cand_t;

    // one neighbour slot transaction
    typedef struct packed {
        logic               valid;
        logic [ID_W-1:0]    id;
        logic [DIST_W-1:0]  dist_sq;
        logic               last;
    } slot_rec_t;

    typedef slot_rec_t slot_set_t [K];

    // directed table: register writes, candidates checked against the model,
    // and candidates whose slot dump is typed in (slot 0 given, the rest empty)
    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_CAND,
        ROW_KNOWN
    } row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic [1:0]        reg_idx;
        logic [31:0]       reg_val;
        cand_t             cand;
        slot_rec_t         head;
        logic [DIST_W-1:0] empty;
    } row_t;

    // clock, reset and all block inputs start at known values
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               first = 1'b0;
    logic               last = 1'b0;
    logic [COORD_W-1:0] cand_x = '0;
    logic [COORD_W-1:0] cand_y = '0;
    logic [ID_W-1:0]    cand_id = '0;

    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               slot_valid;
    logic [ID_W-1:0]    neighbour_id;
    logic [DIST_W-1:0]  neighbour_dist_sq;
    logic               slot_last;

    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    // selection model state: registers, slots, index of the worst slot
    logic [COORD_W-1:0] query_x_q;
    logic [COORD_W-1:0] query_y_q;
    logic [LIMIT_W-1:0] limit_q;
    logic [DIST_W-1:0]  slot_dist [K];
    logic [ID_W-1:0]    slot_id [K];
    int                 worst_idx;

    // slot transactions still owed by the block, oldest first
    slot_rec_t pending_slots [$];

    int mismatches = 0;
    int items_sent = 0;
    int burst_left = 0;

    // receiver stall pattern state
    int stall_mode = 0;
    int mode_left = 0;
    int stall_phase = 0;

    k_nearest_point_selector_unit #(
        .K(K)
    ) i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .first             (first),
        .last              (last),
        .cand_x            (cand_x),
        .cand_y            (cand_y),
        .cand_id           (cand_id),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .slot_valid        (slot_valid),
        .neighbour_id      (neighbour_id),
        .neighbour_dist_sq (neighbour_dist_sq),
        .slot_last         (slot_last),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void note_failure(input string msg);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%s", msg);
        end
    endfunction

    // limit squared, saturating at the top of the 49-bit distance range
    function automatic logic [DIST_W-1:0] limit_square();
        logic [2*LIMIT_W-1:0] prod;
        prod = limit_q * limit_q;
        if (prod > {1'b0, DIST_MAX})
        begin
            return DIST_MAX;
        end
        return prod[DIST_W-1:0];
    endfunction

    function automatic void model_reset();
        query_x_q = '0;
        query_y_q = '0;
        limit_q = LIMIT_RESET;
        for (int i = 0; i < K; i++)
        begin
            slot_dist[i] = limit_square();
            slot_id[i] = '0;
        end
        worst_idx = 0;
    endfunction

    // one candidate through the selection; returns 1 when the slots are dumped
    function automatic bit nearest_update(input cand_t c, output slot_set_t snap);
        logic [DIST_W-1:0]  lsq;
        logic [DIST_W-1:0]  d;
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
        int                 w;
        lsq = limit_square();
        if (worst_idx >= K)
        begin
            worst_idx = 0;
        end
        if (c.first)
        begin
            for (int i = 0; i < K; i++)
            begin
                slot_dist[i] = lsq;
                slot_id[i] = '0;
            end
            worst_idx = 0;
        end
        // a candidate on the query column is skipped whatever its y
        if (c.x != query_x_q)
        begin
            dx = (c.x >= query_x_q) ? c.x - query_x_q : query_x_q - c.x;
            dy = (c.y >= query_y_q) ? c.y - query_y_q : query_y_q - c.y;
            d = dx * dx + dy * dy;
            w = worst_idx;
            // ties with the worst slot lose
            if (d < slot_dist[w])
            begin
                slot_dist[w] = d;
                slot_id[w] = c.id;
                for (int i = 0; i < K; i++)
                begin
                    if (slot_dist[i] > slot_dist[w])
                    begin
                        w = i;
                    end
                end
                worst_idx = w;
            end
        end
        for (int i = 0; i < K; i++)
        begin
            snap[i].valid = slot_dist[i] < lsq;
            snap[i].id = slot_id[i];
            snap[i].dist_sq = slot_dist[i];
            snap[i].last = (i == K - 1);
        end
        return c.last;
    endfunction

    function automatic row_t cfg_row(input logic [1:0] idx, input logic [31:0] val);
        row_t r;
        r.kind = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = val;
        r.cand = '0;
        r.head = '0;
        r.empty = '0;
        return r;
    endfunction

    function automatic row_t cand_row(input logic f, input logic l,
                                      input logic [COORD_W-1:0] x,
                                      input logic [COORD_W-1:0] y,
                                      input logic [ID_W-1:0] id);
        row_t r;
        r = cfg_row(knps_pkg::REG_QUERY_X, '0);
        r.kind = ROW_CAND;
        r.cand.first = f;
        r.cand.last = l;
        r.cand.x = x;
        r.cand.y = y;
        r.cand.id = id;
        return r;
    endfunction

    // first and last on a single candidate: slot 0 as given, all others empty
    function automatic row_t known_row(input logic [COORD_W-1:0] x,
                                       input logic [COORD_W-1:0] y,
                                       input logic [ID_W-1:0] id,
                                       input logic hv, input logic [ID_W-1:0] hid,
                                       input logic [DIST_W-1:0] hdist,
                                       input logic [DIST_W-1:0] empty);
        row_t r;
        r = cand_row(1'b1, 1'b1, x, y, id);
        r.kind = ROW_KNOWN;
        r.head.valid = hv;
        r.head.id = hid;
        r.head.dist_sq = hdist;
        r.head.last = 1'b0;
        r.empty = empty;
        return r;
    endfunction

    // apb write: setup cycle, then access cycle until pready
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            knps_pkg::REG_QUERY_X: query_x_q = val[COORD_W-1:0];
            knps_pkg::REG_QUERY_Y: query_y_q = val[COORD_W-1:0];
            knps_pkg::REG_LIMIT:   limit_q = val[LIMIT_W-1:0];
            default:               ;
        endcase
    endtask

    // drop valid and hold off until every owed slot has come out and the
    // block has had time to finish any candidate that dumps nothing
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_slots.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // one candidate transaction, then burst/gap pacing of the sender
    task automatic send_cand(input cand_t c, input bit typed, input slot_rec_t head,
                             input logic [DIST_W-1:0] empty);
        slot_set_t snap;
        slot_rec_t rec;
        bit        emits;
        in_valid <= 1'b1;
        first <= c.first;
        last <= c.last;
        cand_x <= c.x;
        cand_y <= c.y;
        cand_id <= c.id;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        emits = nearest_update(c, snap);
        if (emits)
        begin
            for (int i = 0; i < K; i++)
            begin
                rec = snap[i];
                if (typed)
                begin
                    if (i == 0)
                    begin
                        rec = head;
                    end
                    else
                    begin
                        rec.valid = 1'b0;
                        rec.id = '0;
                        rec.dist_sq = empty;
                        rec.last = (i == K - 1);
                    end
                end
                pending_slots.push_back(rec);
            end
        end
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 6);
        end
    endtask

    // coordinates cluster around the query, with extremes and full-range noise
    function automatic logic [COORD_W-1:0] pick_coord(input logic [COORD_W-1:0] q);
        logic [COORD_W-1:0] off;
        off = COORD_W'($urandom_range(0, 40));
        case ($urandom_range(0, 7))
            0:       return q;
            1, 2, 3: return q + off - 12'd20;
            4:       return '0;
            5:       return '1;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    // new register settings, upper data bits random to exercise masking
    task automatic random_settings();
        logic [31:0] val;
        val = $urandom;
        case ($urandom_range(0, 3))
            0:       val[COORD_W-1:0] = '0;
            1:       val[COORD_W-1:0] = '1;
            default: ;
        endcase
        reg_write(knps_pkg::REG_QUERY_X, val);
        val = $urandom;
        case ($urandom_range(0, 3))
            0:       val[COORD_W-1:0] = '0;
            1:       val[COORD_W-1:0] = '1;
            default: ;
        endcase
        reg_write(knps_pkg::REG_QUERY_Y, val);
        val = $urandom;
        case ($urandom_range(0, 7))
            0:       val[LIMIT_W-1:0] = '0;
            1:       val[LIMIT_W-1:0] = 25'd1;
            2:       val[LIMIT_W-1:0] = LIMIT_RESET;
            3:       val[LIMIT_W-1:0] = 25'd23726566;   // largest unsaturated square
            4:       val[LIMIT_W-1:0] = 25'd23726567;
            5:       val[LIMIT_W-1:0] = '1;
            6:       val[LIMIT_W-1:0] = LIMIT_W'($urandom_range(1, 6000));
            default: ;
        endcase
        reg_write(knps_pkg::REG_LIMIT, val);
        if ($urandom_range(0, 3) == 0)
        begin
            reg_write(REG_UNUSED, $urandom);
        end
    endtask

    // output checker and receiver stall pattern
    always @(posedge clk)
    begin
        slot_rec_t got;
        slot_rec_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {slot_valid, neighbour_id, neighbour_dist_sq, slot_last};
            if (pending_slots.size() == 0)
            begin
                note_failure($sformatf({"unexpected slot transaction:",
                                        " valid %0b id %h dist %0d last %0b"},
                                       got.valid, got.id, got.dist_sq, got.last));
            end
            else
            begin
                want = pending_slots.pop_front();
                if (got.valid !== want.valid || got.id !== want.id ||
                    got.dist_sq !== want.dist_sq || got.last !== want.last)
                begin
                    note_failure($sformatf({"slot mismatch: expected valid %0b id %h",
                                            " dist %0d last %0b,",
                                            " got valid %0b id %h dist %0d last %0b"},
                                           want.valid, want.id, want.dist_sq, want.last,
                                           got.valid, got.id, got.dist_sq, got.last));
                end
            end
        end
        // stall modes: none, coin flip, or a repeating pattern stepped by stall_phase
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(16, 64);
        end
        else
        begin
            mode_left--;
        end
        stall_phase++;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= 1'($urandom_range(0, 1));
            default: out_stall <= (stall_phase % 8) < 5;
        endcase
    end

    // stimulus: directed table, then random candidate runs
    initial
    begin
        row_t  rows [$];
        cand_t c;
        int    run_len;
        int    random_goal;
        bit    noisy;

        model_reset();

        // reset settings: query at the origin, limit 2^24
        // candidate on the query column is skipped even with y far away
        rows.push_back(known_row(12'd0, 12'd4095, 16'hFFFF, 1'b0, 16'h0, DIST_RESET,
                                 DIST_RESET));
        // 3-4-5 triangle
        rows.push_back(known_row(12'd3, 12'd4, 16'h1234, 1'b1, 16'h1234, 49'd25,
                                 DIST_RESET));
        // far corner
        rows.push_back(known_row(12'd4095, 12'd4095, 16'hFFFF, 1'b1, 16'hFFFF,
                                 49'd33538050, DIST_RESET));
        // nearest possible point, id zero
        rows.push_back(known_row(12'd1, 12'd0, 16'h0000, 1'b1, 16'h0000, 49'd1,
                                 DIST_RESET));
        // fill all slots, tie with the worst, column skip, closer replaces
        rows.push_back(cand_row(1'b1, 1'b0, 12'd5, 12'd0, 16'h0001));
        rows.push_back(cand_row(1'b0, 1'b0, 12'd1, 12'd1, 16'h0002));
        rows.push_back(cand_row(1'b0, 1'b0, 12'd0, 12'd7, 16'h0003));
        rows.push_back(cand_row(1'b0, 1'b0, 12'd2, 12'd2, 16'h0004));
        rows.push_back(cand_row(1'b0, 1'b0, 12'd6, 12'd0, 16'h0005));
        rows.push_back(cand_row(1'b0, 1'b0, 12'd3, 12'd3, 16'h0006));
        rows.push_back(cand_row(1'b0, 1'b0, 12'd4, 12'd4, 16'h0007));
        rows.push_back(cand_row(1'b0, 1'b0, 12'd6, 12'd1, 16'h0008));
        rows.push_back(cand_row(1'b0, 1'b0, 12'd1, 12'd6, 16'h0009));
        rows.push_back(cand_row(1'b0, 1'b1, 12'd1, 12'd0, 16'h000B));
        // no first mark: continues on the slots left by the previous run
        rows.push_back(cand_row(1'b0, 1'b1, 12'd2047, 12'd2048, 16'h000C));
        // query at the far corner with zero limit: nothing can be taken
        rows.push_back(cfg_row(knps_pkg::REG_QUERY_X, 32'd4095));
        rows.push_back(cfg_row(knps_pkg::REG_QUERY_Y, 32'd4095));
        rows.push_back(cfg_row(knps_pkg::REG_LIMIT, 32'd0));
        rows.push_back(known_row(12'd0, 12'd0, 16'hABCD, 1'b0, 16'h0, 49'd0, 49'd0));
        // largest limit saturates its square
        rows.push_back(cfg_row(knps_pkg::REG_LIMIT, 32'h01FF_FFFF));
        rows.push_back(known_row(12'd4095, 12'd0, 16'h0001, 1'b0, 16'h0, DIST_MAX,
                                 DIST_MAX));
        rows.push_back(known_row(12'd0, 12'd0, 16'h8000, 1'b1, 16'h8000, 49'd33538050,
                                 DIST_MAX));
        // largest limit whose square still fits
        rows.push_back(cfg_row(knps_pkg::REG_LIMIT, 32'd23726566));
        rows.push_back(cand_row(1'b1, 1'b1, 12'd4094, 12'd4095, 16'h0003));
        // limit 5: a distance equal to the limit squared stays out
        rows.push_back(cfg_row(knps_pkg::REG_LIMIT, 32'd5));
        rows.push_back(cand_row(1'b1, 1'b0, 12'd4091, 12'd4092, 16'h0010));
        rows.push_back(cand_row(1'b0, 1'b1, 12'd4094, 12'd4095, 16'h0011));
        // write to an index past the register list is dropped
        rows.push_back(cfg_row(REG_UNUSED, 32'hFFFF_FFFF));
        rows.push_back(cand_row(1'b1, 1'b1, 12'd4092, 12'd4091, 16'h0012));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[r])
        begin
            case (rows[r].kind)
                ROW_CFG:
                begin
                    wait_idle();
                    reg_write(rows[r].reg_idx, rows[r].reg_val);
                end
                ROW_KNOWN: send_cand(rows[r].cand, 1'b1, rows[r].head, rows[r].empty);
                default:   send_cand(rows[r].cand, 1'b0, '0, '0);
            endcase
        end

        // random runs: mostly first..last sequences, some with random marks
        random_goal = items_sent + RANDOM_ITEMS;
        while (items_sent < random_goal)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                wait_idle();
                random_settings();
            end
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24)
                                                  : $urandom_range(1, 8);
            noisy = ($urandom_range(0, 7) == 0);
            for (int k = 0; k < run_len; k++)
            begin
                // occasionally move the query point in the middle of a run
                if (!noisy && k > 0 && k < run_len - 1 && $urandom_range(0, 19) == 0)
                begin
                    wait_idle();
                    reg_write(knps_pkg::REG_QUERY_Y, $urandom);
                end
                c.first = noisy ? 1'($urandom) : (k == 0);
                c.last = noisy ? 1'($urandom) : (k == run_len - 1);
                c.x = pick_coord(query_x_q);
                c.y = pick_coord(query_y_q);
                c.id = ID_W'($urandom);
                send_cand(c, 1'b0, '0, '0);
            end
        end

        // drain, then allow for anything still in work
        wait_idle();
        repeat (SETTLE) @(posedge clk);
        if (pending_slots.size() != 0)
        begin
            note_failure($sformatf("%0d slot transactions never arrived",
                                   pending_slots.size()));
        end
        if (mismatches == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #1_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
